// ----- rtl/core/grid_min_effort_bisect_flood_macros.svh -----
// assertion macros shared by the flood search rtl
// no dependencies; included by the top level
`ifndef GRID_MIN_EFFORT_BISECT_FLOOD_MACROS_SVH
`define GRID_MIN_EFFORT_BISECT_FLOOD_MACROS_SVH

// implication in the same cycle, disabled during reset
`define GMEF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication in the next cycle, disabled during reset
`define GMEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/gmef_pkg.sv -----
// types and constants of the grid minimum-effort flood search
// no dependencies
`default_nettype none
package gmef_pkg;

  localparam int HEIGHT_W = 20;
  localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 20'd999999;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 8'd1;

  // neighbour order: right, left, down, up
  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_MID   = 8'b0000_0010,
    ST_CLEAR = 8'b0000_0100,
    ST_SEED  = 8'b0000_1000,
    ST_POP   = 8'b0001_0000,
    ST_POPW  = 8'b0010_0000,
    ST_NREQ  = 8'b0100_0000,
    ST_NCHK  = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/gmef_if.sv -----
// valid/ready channels of the flood search block
// depends on gmef_pkg
`default_nettype none
interface gmef_in_if import gmef_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;
  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

interface gmef_out_if import gmef_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] min_effort;
  modport source (output valid, output min_effort, input ready);
  modport sink   (input valid, input min_effort, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/gmef_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module gmef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/grid_min_effort_bisect_flood.sv -----
// grid minimum-effort search: height load, bisection and breadth-first flood
// depends on gmef_pkg, gmef_if, gmef_ram and the macros header
//
// usage
//   in_if  : one height per transfer, row-major, saturated at 999999
//   out_if : one min_effort per grid, given after the last cell of the grid
//   cfg_*  : index 0 row_count, index 1 col_count; a write restarts the load
// throughput and search steps
//   loading takes one cell per cycle while in_if.ready is high, in ST_LOAD only
//   after the last cell the block runs up to 20 bisection passes; each pass
//   clears the visited map over the cells in use, seeds the first cell, then
//   pops each reached cell and checks its four neighbours in turn, one at a
//   time, set by the single read port of each ram
// stalls
//   the result sits in an output register; the next grid loads meanwhile,
//   only its last cell waits until the pending result has been transferred
// reset
//   synchronous, active low: registers 1x1 grid, load count zero, no result
//   the rams need no clearing; the visited map is cleared at every pass
`default_nettype none
`include "grid_min_effort_bisect_flood_macros.svh"
module grid_min_effort_bisect_flood import gmef_pkg::*; #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  gmef_in_if.sink                    in_if,
  gmef_out_if.source                 out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int CIW   = DEPTH > 1 ? $clog2(DEPTH) : 1;     // cell index
  localparam int CNW   = $clog2(DEPTH + 1);                 // cell count
  localparam int RIW   = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int KIW   = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int KNW   = $clog2(MAX_COLS + 1);
  localparam int SW    = (RNW > KNW ? RNW : KNW) > CFG_DATA_W ?
                         (RNW > KNW ? RNW : KNW) + 1 : CFG_DATA_W + 1;
  localparam int QW    = CIW + RIW + KIW;

  // configuration and clamped grid size
  logic [CFG_DATA_W-1:0] row_count_r, col_count_r;
  logic [RNW-1:0]        rows_used;
  logic [KNW-1:0]        cols_used;
  logic [CNW-1:0]        total, total_m1;

  always_comb begin
    if (row_count_r == '0) begin
      rows_used = RNW'(1);
    end else if (SW'(row_count_r) > SW'(MAX_ROWS)) begin
      rows_used = RNW'(MAX_ROWS);
    end else begin
      rows_used = RNW'(row_count_r);
    end
    if (col_count_r == '0) begin
      cols_used = KNW'(1);
    end else if (SW'(col_count_r) > SW'(MAX_COLS)) begin
      cols_used = KNW'(MAX_COLS);
    end else begin
      cols_used = KNW'(col_count_r);
    end
  end

  assign total    = CNW'(CNW'(rows_used) * CNW'(cols_used));
  assign total_m1 = total - CNW'(1);

  // sequencer state
  state_t               state_r;
  logic [CNW-1:0]       loaded_r;
  logic [CNW-1:0]       clr_r;
  logic [CNW-1:0]       head_r, tail_r;
  logic [HEIGHT_W-1:0]  low_r;
  logic signed [HEIGHT_W:0] high_r;
  logic [HEIGHT_W-1:0]  best_r, mid_r;
  logic                 reached_r;
  dir_t                 dir_r;
  logic [CIW-1:0]       cur_cell_r, nb_cell_r;
  logic [RIW-1:0]       cur_row_r;
  logic [KIW-1:0]       cur_col_r;
  logic [RIW-1:0]       nb_row_r;
  logic [KIW-1:0]       nb_col_r;
  logic [HEIGHT_W-1:0]  cur_h_r;
  logic                 out_valid_r;
  logic [HEIGHT_W-1:0]  out_data_r;

  // ram ports
  logic                h_we, v_we, q_we;
  logic [CIW-1:0]      h_waddr, h_raddr, v_waddr, v_raddr, q_waddr, q_raddr;
  logic [HEIGHT_W-1:0] h_wdata, h_rdata;
  logic                v_wdata, v_rdata;
  logic [QW-1:0]       q_wdata, q_rdata;

  gmef_ram #(.WIDTH(HEIGHT_W), .DEPTH(DEPTH)) u_height (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );
  gmef_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_visited (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );
  gmef_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // input side
  logic                in_xfer, last_cell;
  logic [HEIGHT_W-1:0] h_sat;

  assign last_cell    = loaded_r >= total_m1;
  assign in_if.ready  = (state_r == ST_LOAD) && !(out_valid_r && last_cell);
  assign in_xfer      = in_if.valid && in_if.ready;
  assign h_sat        = (in_if.height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : in_if.height;

  assign out_if.valid      = out_valid_r;
  assign out_if.min_effort = out_data_r;

  // neighbour of the current cell in the current direction
  logic           nb_ok;
  logic [CIW-1:0] nb_cell;
  logic [RIW-1:0] nb_row;
  logic [KIW-1:0] nb_col;

  always_comb begin
    nb_ok   = 1'b0;
    nb_cell = cur_cell_r;
    nb_row  = cur_row_r;
    nb_col  = cur_col_r;
    case (dir_r)
      DIR_RIGHT: begin
        nb_ok   = SW'(cur_col_r) + SW'(1) < SW'(cols_used);
        nb_col  = cur_col_r + KIW'(1);
        nb_cell = cur_cell_r + CIW'(1);
      end
      DIR_LEFT: begin
        nb_ok   = cur_col_r != '0;
        nb_col  = cur_col_r - KIW'(1);
        nb_cell = cur_cell_r - CIW'(1);
      end
      DIR_DOWN: begin
        nb_ok   = SW'(cur_row_r) + SW'(1) < SW'(rows_used);
        nb_row  = cur_row_r + RIW'(1);
        nb_cell = CIW'(CNW'(cur_cell_r) + CNW'(cols_used));
      end
      DIR_UP: begin
        nb_ok   = cur_row_r != '0;
        nb_row  = cur_row_r - RIW'(1);
        nb_cell = CIW'(CNW'(cur_cell_r) - CNW'(cols_used));
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  // step check on the neighbour read back from the rams
  logic [HEIGHT_W-1:0] diff;
  logic                nb_take;
  assign diff    = (cur_h_r > h_rdata) ? cur_h_r - h_rdata : h_rdata - cur_h_r;
  assign nb_take = !v_rdata && (diff <= mid_r);

  // ram control
  always_comb begin
    h_we    = in_xfer;
    h_waddr = loaded_r[CIW-1:0];
    h_wdata = h_sat;
    h_raddr = (state_r == ST_POPW) ? q_rdata[QW-1 -: CIW] : nb_cell;
    v_we    = 1'b0;
    v_waddr = nb_cell_r;
    v_wdata = 1'b1;
    v_raddr = nb_cell;
    q_we    = 1'b0;
    q_waddr = tail_r[CIW-1:0];
    q_wdata = {nb_cell_r, nb_row_r, nb_col_r};
    q_raddr = head_r[CIW-1:0];
    case (state_r)
      ST_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr_r[CIW-1:0];
        v_wdata = 1'b0;
      end
      ST_SEED: begin
        v_we    = 1'b1;
        v_waddr = '0;
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = '0;
      end
      ST_NCHK: begin
        v_we = nb_take;
        q_we = nb_take;
      end
      default: begin
        v_we = 1'b0;
      end
    endcase
  end

  // bisection bounds after a finished pass
  logic [HEIGHT_W:0] mid_sum;
  assign mid_sum = {1'b0, low_r} + {1'b0, high_r[HEIGHT_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      row_count_r <= CFG_DATA_W'(1);
      col_count_r <= CFG_DATA_W'(1);
      loaded_r    <= '0;
      low_r       <= '0;
      high_r      <= {1'b0, HEIGHT_LIMIT};
      best_r      <= '0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      clr_r       <= '0;
      reached_r   <= 1'b0;
      dir_r       <= DIR_RIGHT;
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      // a register write restarts the load
      if (cfg_we) begin
        if (cfg_index == CFG_ROW_COUNT) begin
          row_count_r <= cfg_data;
          loaded_r    <= '0;
        end else if (cfg_index == CFG_COL_COUNT) begin
          col_count_r <= cfg_data;
          loaded_r    <= '0;
        end
      end
      case (state_r)
        ST_LOAD: begin
          if (in_xfer) begin
            if (last_cell) begin
              loaded_r <= '0;
              low_r    <= '0;
              high_r   <= {1'b0, HEIGHT_LIMIT};
              best_r   <= '0;
              state_r  <= ST_MID;
            end else begin
              loaded_r <= loaded_r + CNW'(1);
            end
          end
        end
        ST_MID: begin
          if ($signed({1'b0, low_r}) <= high_r) begin
            mid_r   <= mid_sum[HEIGHT_W:1];
            clr_r   <= '0;
            state_r <= ST_CLEAR;
          end else begin
            out_data_r  <= best_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_LOAD;
          end
        end
        ST_CLEAR: begin
          // visited map wiped over the cells in use
          if (clr_r >= total_m1) begin
            state_r <= ST_SEED;
          end else begin
            clr_r <= clr_r + CNW'(1);
          end
        end
        ST_SEED: begin
          head_r    <= '0;
          tail_r    <= CNW'(1);
          reached_r <= total_m1 == '0;
          state_r   <= ST_POP;
        end
        ST_POP: begin
          if (head_r == tail_r) begin
            // queue drained: the pass is over
            if (reached_r) begin
              best_r <= mid_r;
              high_r <= $signed({1'b0, mid_r}) - (HEIGHT_W + 1)'(1);
            end else begin
              low_r <= mid_r + HEIGHT_W'(1);
            end
            state_r <= ST_MID;
          end else begin
            head_r  <= head_r + CNW'(1);
            state_r <= ST_POPW;
          end
        end
        ST_POPW: begin
          {cur_cell_r, cur_row_r, cur_col_r} <= q_rdata;
          state_r <= ST_NREQ;
          dir_r   <= DIR_RIGHT;
        end
        ST_NREQ: begin
          // first cycle here also receives the popped cell's height
          if (dir_r == DIR_RIGHT) begin
            cur_h_r <= h_rdata;
          end
          if (nb_ok) begin
            nb_cell_r <= nb_cell;
            nb_row_r  <= nb_row;
            nb_col_r  <= nb_col;
            state_r   <= ST_NCHK;
          end else if (dir_r == DIR_UP) begin
            state_r <= ST_POP;
          end else begin
            dir_r <= dir_t'(dir_r + 2'd1);
          end
        end
        ST_NCHK: begin
          if (nb_take) begin
            tail_r <= tail_r + CNW'(1);
            if (CNW'(nb_cell_r) == total_m1) begin
              reached_r <= 1'b1;
            end
          end
          if (dir_r == DIR_UP) begin
            state_r <= ST_POP;
          end else begin
            dir_r   <= dir_t'(dir_r + 2'd1);
            state_r <= ST_NREQ;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  // cur_h_r is loaded on the first neighbour request, while the height
  // read issued in ST_POPW is on h_rdata; the right neighbour read issued in
  // that same cycle returns in the next cycle, in ST_NCHK

  `GMEF_ASSERT_IMPL(a_ready_only_loading, clk, rst_n, in_if.ready, state_r == ST_LOAD)
  `GMEF_ASSERT_IMPL(a_queue_order, clk, rst_n, state_r != ST_LOAD, head_r <= tail_r)
  `GMEF_ASSERT_NEXT(a_result_after_mid, clk, rst_n,
                    !out_valid_r && state_r != ST_MID, !out_valid_r)
endmodule
`default_nettype wire
